// ===== hw/rtl/binary_frame_receiver_with_sum_check_macros.svh =====
// assertion helpers for the frame receiver
`ifndef BINARY_FRAME_RECEIVER_WITH_SUM_CHECK_MACROS_SVH
`define BINARY_FRAME_RECEIVER_WITH_SUM_CHECK_MACROS_SVH

`ifndef SYNTHESIS
`define BFR_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
`define BFR_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define BFR_ASSERT_IMP(label, clk, rst, pre, post, msg)
`define BFR_ASSERT_NXT(label, clk, rst, pre, post, msg)
`endif

`endif

// ===== hw/rtl/bfr_pkg.sv =====
`default_nettype none

package bfr_pkg;

   localparam int unsigned LEN_BITS_DEFAULT = 15;
   localparam int unsigned SUM_W            = 15;

   localparam logic [7:0]       SYNC_A        = 8'hA0;
   localparam logic [7:0]       SYNC_B        = 8'hA2;
   localparam logic [SUM_W-1:0] MAX_LEN_RESET = 15'd1016;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [1:0] VERDICT_GOOD     = 2'd0;
   localparam logic [1:0] VERDICT_BAD_SUM  = 2'd1;
   localparam logic [1:0] VERDICT_OVERSIZE = 2'd2;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data_byte;
      logic [SUM_W-1:0] byte_index;
      logic [1:0]       verdict;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bfr_req_if.sv =====
`default_nettype none

interface bfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bfr_rsp_if.sv =====
`default_nettype none

interface bfr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [7:0]                 data_byte;
   logic [bfr_pkg::SUM_W-1:0]  byte_index;
   logic [1:0]                 verdict;
   logic                       last;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output verdict, output last, input ready);
   modport sink (input valid, input kind, input data_byte, input byte_index,
                 input verdict, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bfr_req_reg.sv =====
`default_nettype none

module bfr_req_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   bfr_req_if.sink         req_ch,
   input  wire logic       fire,
   output logic            item_valid,
   output logic [7:0]      item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // holding register frees up in the same cycle the parser consumes it
   assign take         = !valid_ff || fire;
   assign req_ch.ready = take;
   assign valid_in     = take ? req_ch.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take && req_ch.valid) begin
         byte_ff <= req_ch.rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bfr_parser.sv =====
`default_nettype none

module bfr_parser #(
   parameter int unsigned LEN_BITS = bfr_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_valid,
   input  wire logic [7:0]                 item_byte,
   input  wire logic [bfr_pkg::SUM_W-1:0]  max_len,
   input  wire logic                       out_free,
   output logic                            fire,
   output logic                            load,
   output bfr_pkg::rsp_type                rsp
);

   localparam int unsigned LenW = (LEN_BITS < bfr_pkg::SUM_W) ? LEN_BITS : bfr_pkg::SUM_W;

   typedef enum logic [2:0] {
      PH_HUNT1, PH_HUNT2, PH_LENHI, PH_LENLO,
      PH_PAYLOAD, PH_CKHI, PH_CKLO, PH_TRAILER
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [7:0]                 hi_ff, hi_in;
   logic [LenW-1:0]            len_ff, len_in;
   logic [LenW-1:0]            cnt_ff, cnt_in;
   logic [bfr_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [bfr_pkg::SUM_W-1:0]  ck_ff, ck_in;
   logic                       trail_ff, trail_in;

   logic [15:0]                word;
   logic [LenW-1:0]            word_len;
   logic [LenW-1:0]            cnt_inc;
   logic                       produce;
   bfr_pkg::rsp_type           rsp_c;

   assign word     = {hi_ff, item_byte};
   assign word_len = word[LenW-1:0];
   assign cnt_inc  = cnt_ff + LenW'(1);

   always_comb begin
      phase_in = phase_ff;
      hi_in    = hi_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      ck_in    = ck_ff;
      trail_in = trail_ff;
      produce  = 1'b0;
      rsp_c    = '0;
      unique case (phase_ff)
         PH_HUNT1: begin
            if (item_byte == bfr_pkg::SYNC_A) begin
               phase_in = PH_HUNT2;
            end
         end
         PH_HUNT2: begin
            if (item_byte == bfr_pkg::SYNC_B) begin
               phase_in = PH_LENHI;
            end else if (item_byte != bfr_pkg::SYNC_A) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_LENHI: begin
            hi_in    = item_byte;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            len_in = word_len;
            sum_in = '0;
            cnt_in = '0;
            if (bfr_pkg::SUM_W'(word_len) > max_len) begin
               produce       = 1'b1;
               rsp_c.kind    = bfr_pkg::KIND_VERDICT;
               rsp_c.verdict = bfr_pkg::VERDICT_OVERSIZE;
               rsp_c.last    = 1'b1;
               phase_in      = PH_HUNT1;
            end else if (word_len == '0) begin
               phase_in = PH_CKHI;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            produce          = 1'b1;
            rsp_c.kind       = bfr_pkg::KIND_DATA;
            rsp_c.data_byte  = item_byte;
            rsp_c.byte_index = bfr_pkg::SUM_W'(cnt_ff);
            sum_in           = sum_ff + bfr_pkg::SUM_W'(item_byte);
            cnt_in           = cnt_inc;
            if (cnt_inc >= len_ff) begin
               cnt_in   = '0;
               phase_in = PH_CKHI;
            end
         end
         PH_CKHI: begin
            hi_in    = item_byte;
            phase_in = PH_CKLO;
         end
         PH_CKLO: begin
            // top bit of the checksum word plays no part in the compare
            ck_in    = word[bfr_pkg::SUM_W-1:0];
            trail_in = 1'b0;
            phase_in = PH_TRAILER;
         end
         PH_TRAILER: begin
            if (!trail_ff) begin
               trail_in = 1'b1;
            end else begin
               produce       = 1'b1;
               rsp_c.kind    = bfr_pkg::KIND_VERDICT;
               rsp_c.verdict = (ck_ff == sum_ff) ? bfr_pkg::VERDICT_GOOD
                                                 : bfr_pkg::VERDICT_BAD_SUM;
               rsp_c.last    = 1'b1;
               phase_in      = PH_HUNT1;
            end
         end
         default: begin
            phase_in = PH_HUNT1;
         end
      endcase
   end

   // a byte that yields nothing never waits on the result side
   assign fire = item_valid && (!produce || out_free);
   assign load = fire && produce;
   assign rsp  = rsp_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
      end else if (fire) begin
         phase_ff <= phase_in;
      end
      if (fire) begin
         hi_ff    <= hi_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         ck_ff    <= ck_in;
         trail_ff <= trail_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bfr_rsp_reg.sv =====
`default_nettype none

module bfr_rsp_reg (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  bfr_pkg::rsp_type rsp_in,
   output logic             out_free,
   bfr_rsp_if.source        rsp_ch
);

   logic             valid_ff;
   bfr_pkg::rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.kind       = data_ff.kind;
   assign rsp_ch.data_byte  = data_ff.data_byte;
   assign rsp_ch.byte_index = data_ff.byte_index;
   assign rsp_ch.verdict    = data_ff.verdict;
   assign rsp_ch.last       = data_ff.last;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_frame_receiver_with_sum_check.sv =====
// Frame receiver with a 15-bit payload sum check.
// req_ch carries one received serial byte per request. The receiver hunts for
// the sync pair A0 A2, reads a big-endian length, passes each payload byte out
// on rsp_ch with its index, then reads the checksum word and two trailer bytes.
// The second trailer byte yields a verdict item (good or sum mismatch) with
// last set; a length above csr max yields an oversize verdict at once.
// Sync, length, checksum and first trailer bytes give no response.
// Path: a byte is held in the request register and its response is
// loaded into the response register, which drives rsp valid. Throughput:
// one byte per cycle while rsp_ch accepts, set by the combinational update
// of the frame state between those two registers.
// csr_wr_en/csr_wr_data set the largest accepted length (1016 after reset).
// Reset returns the receiver to the sync hunt and empties both registers.
// When rsp_ch stalls, bytes that give no response still flow; a byte that
// gives one waits in the request register and req_ch.ready drops.

`default_nettype none

`include "binary_frame_receiver_with_sum_check_macros.svh"

module binary_frame_receiver_with_sum_check #(
   parameter int unsigned LEN_BITS = bfr_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bfr_req_if.sink                         req_ch,
   bfr_rsp_if.source                       rsp_ch,
   input  wire logic                       csr_wr_en,
   input  wire logic [bfr_pkg::SUM_W-1:0]  csr_wr_data
);

   logic [bfr_pkg::SUM_W-1:0]  max_len_ff;
   logic                       item_valid;
   logic [7:0]                 item_byte;
   logic                       fire;
   logic                       load;
   logic                       out_free;
   bfr_pkg::rsp_type           rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= bfr_pkg::MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   bfr_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .fire       (fire),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   bfr_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .max_len    (max_len_ff),
      .out_free   (out_free),
      .fire       (fire),
      .load       (load),
      .rsp        (rsp)
   );

   bfr_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .rsp_in   (rsp),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   `BFR_ASSERT_NXT(a_item_kept, clock, reset, item_valid && !fire,
                   item_valid && $stable(item_byte), "held request lost")
   `BFR_ASSERT_IMP(a_ready_only_when_free, clock, reset, !req_ch.ready,
                   item_valid && !fire, "request stalled without cause")
   `BFR_ASSERT_IMP(a_data_fields, clock, reset,
                   rsp_ch.valid && (rsp_ch.kind == bfr_pkg::KIND_DATA),
                   (rsp_ch.last == 1'b0) && (rsp_ch.verdict == bfr_pkg::VERDICT_GOOD),
                   "payload item carries verdict")
   `BFR_ASSERT_IMP(a_verdict_fields, clock, reset,
                   rsp_ch.valid && (rsp_ch.kind == bfr_pkg::KIND_VERDICT),
                   rsp_ch.last && (rsp_ch.data_byte == 8'd0) && (rsp_ch.byte_index == '0),
                   "verdict item malformed")

endmodule

`default_nettype wire

// ===== tb/sv/bfr_frame_checker.sv =====
`timescale 1ns / 1ps

module bfr_frame_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bfr_req_if                              req_mon,
   bfr_rsp_if                              rsp_mon,
   input  wire logic                       csr_wr_en,
   input  wire logic [bfr_pkg::SUM_W-1:0]  csr_wr_data,
   output int                              mismatches,
   output int                              outstanding,
   output int                              payload_seen,
   output int                              good_seen,
   output int                              bad_sum_seen,
   output int                              oversize_seen
);

   typedef enum logic [2:0] {
      HUNT_SYNC_A, HUNT_SYNC_B, LEN_HI, LEN_LO, PAYLOAD, CSUM_HI, CSUM_LO, TRAILER
   } rx_phase_type;

   rx_phase_type                rx_phase;
   logic [bfr_pkg::SUM_W-1:0]   max_len;
   logic [bfr_pkg::SUM_W-1:0]   frame_len;
   logic [bfr_pkg::SUM_W-1:0]   payload_sum;
   logic [15:0]                 byte_count;
   logic [15:0]                 csum_word;
   bfr_pkg::rsp_type            expected_q[$];
   int                          error_total;

   function automatic bfr_pkg::rsp_type verdict_item(input logic [1:0] v);
      bfr_pkg::rsp_type item;
      item         = '0;
      item.kind    = bfr_pkg::KIND_VERDICT;
      item.verdict = v;
      item.last    = 1'b1;
      return item;
   endfunction

   // advance the frame state by one received byte, queueing any response
   function automatic void track_rx_byte(input logic [7:0] b);
      bfr_pkg::rsp_type item;
      item = '0;
      case (rx_phase)
         HUNT_SYNC_A: begin
            if (b == bfr_pkg::SYNC_A) rx_phase = HUNT_SYNC_B;
         end
         HUNT_SYNC_B: begin
            if (b == bfr_pkg::SYNC_B) rx_phase = LEN_HI;
            else if (b != bfr_pkg::SYNC_A) rx_phase = HUNT_SYNC_A;
         end
         LEN_HI: begin
            frame_len = {b[6:0], 8'h00};
            rx_phase  = LEN_LO;
         end
         LEN_LO: begin
            frame_len   = {frame_len[14:8], b};
            payload_sum = '0;
            byte_count  = '0;
            if (frame_len > max_len) begin
               expected_q.push_back(verdict_item(bfr_pkg::VERDICT_OVERSIZE));
               rx_phase = HUNT_SYNC_A;
            end else begin
               rx_phase = (frame_len == 0) ? CSUM_HI : PAYLOAD;
            end
         end
         PAYLOAD: begin
            item.kind       = bfr_pkg::KIND_DATA;
            item.data_byte  = b;
            item.byte_index = byte_count[bfr_pkg::SUM_W-1:0];
            item.verdict    = bfr_pkg::VERDICT_GOOD;
            item.last       = 1'b0;
            expected_q.push_back(item);
            payload_sum = payload_sum + bfr_pkg::SUM_W'(b);
            byte_count  = byte_count + 16'd1;
            if (byte_count >= {1'b0, frame_len}) begin
               rx_phase   = CSUM_HI;
               byte_count = '0;
            end
         end
         CSUM_HI: begin
            csum_word = {b, 8'h00};
            rx_phase  = CSUM_LO;
         end
         CSUM_LO: begin
            csum_word[7:0] = b;
            byte_count     = '0;
            rx_phase       = TRAILER;
         end
         TRAILER: begin
            // trailer bytes are not checked, the verdict lands on the second
            if (byte_count == 0) begin
               byte_count = 16'd1;
            end else begin
               byte_count = '0;
               rx_phase   = HUNT_SYNC_A;
               expected_q.push_back(verdict_item(
                  (csum_word[14:0] == payload_sum) ? bfr_pkg::VERDICT_GOOD
                                                   : bfr_pkg::VERDICT_BAD_SUM));
            end
         end
         default: rx_phase = HUNT_SYNC_A;
      endcase
   endfunction

   always @(posedge clock) begin
      bfr_pkg::rsp_type got;
      bfr_pkg::rsp_type want;
      if (reset) begin
         rx_phase    = HUNT_SYNC_A;
         max_len     = bfr_pkg::MAX_LEN_RESET;
         frame_len   = '0;
         payload_sum = '0;
         byte_count  = '0;
         csum_word   = '0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got            = '0;
            got.kind       = rsp_mon.kind;
            got.data_byte  = rsp_mon.data_byte;
            got.byte_index = rsp_mon.byte_index;
            got.verdict    = rsp_mon.verdict;
            got.last       = rsp_mon.last;
            if (expected_q.size() == 0) begin
               if (error_total < 10)
                  $display({"%0t: response with none pending: kind %0d data %02h",
                            " index %0d verdict %0d last %0d"},
                           $realtime, got.kind, got.data_byte, got.byte_index,
                           got.verdict, got.last);
               error_total++;
            end else begin
               want = expected_q.pop_front();
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.byte_index !== want.byte_index || got.verdict !== want.verdict ||
                   got.last !== want.last) begin
                  if (error_total < 10)
                     $display({"%0t: mismatch, expected kind %0d data %02h index %0d",
                               " verdict %0d last %0d, got kind %0d data %02h",
                               " index %0d verdict %0d last %0d"},
                              $realtime, want.kind, want.data_byte, want.byte_index,
                              want.verdict, want.last, got.kind, got.data_byte,
                              got.byte_index, got.verdict, got.last);
                  error_total++;
               end
               if (want.kind == bfr_pkg::KIND_DATA) begin
                  payload_seen <= payload_seen + 1;
               end else if (want.verdict == bfr_pkg::VERDICT_GOOD) begin
                  good_seen <= good_seen + 1;
               end else if (want.verdict == bfr_pkg::VERDICT_BAD_SUM) begin
                  bad_sum_seen <= bad_sum_seen + 1;
               end else begin
                  oversize_seen <= oversize_seen + 1;
               end
            end
         end
         if (csr_wr_en) max_len = csr_wr_data;
         if (req_mon.valid && req_mon.ready) track_rx_byte(req_mon.rx_byte);
      end
      outstanding <= expected_q.size();
      mismatches  <= error_total;
   end

endmodule

// ===== tb/sv/binary_frame_receiver_with_sum_check_tb.sv =====
`timescale 1ns / 1ps

module binary_frame_receiver_with_sum_check_tb;

   localparam int HOLD_CYCLES = 80;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [bfr_pkg::SUM_W-1:0]  csr_wr_data = '0;

   bfr_req_if req_ch ();
   bfr_rsp_if rsp_ch ();

   int mismatches;
   int outstanding;
   int payload_seen;
   int good_seen;
   int bad_sum_seen;
   int oversize_seen;

   logic                       steady = 1'b0;
   int                         hold_asks = 0;
   int                         frame_bytes = 0;
   int                         settings_used = 1;
   logic [bfr_pkg::SUM_W-1:0]  cur_max = bfr_pkg::MAX_LEN_RESET;

   binary_frame_receiver_with_sum_check i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bfr_frame_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .payload_seen  (payload_seen),
      .good_seen     (good_seen),
      .bad_sum_seen  (bad_sum_seen),
      .oversize_seen (oversize_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, sometimes a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int unsigned pick_len();
      int unsigned r;
      int unsigned cap;
      int unsigned max_u;
      max_u = 32'(cur_max);
      r = $urandom_range(99);
      if (r < 10 || max_u == 0) return 0;
      cap = (max_u < 12) ? max_u : 12;
      if (r < 85) return $urandom_range(cap, 1);
      if (r < 90 && max_u <= 64) return max_u;
      cap = (max_u < 40) ? max_u : 40;
      return $urandom_range(cap, 1);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      frame_bytes++;
   endtask

   task automatic send_frame(input int unsigned len, input bit bad_sum);
      logic [bfr_pkg::SUM_W-1:0] l;
      logic [bfr_pkg::SUM_W-1:0] sum;
      logic [15:0]               ck;
      logic [7:0]                b;
      l   = bfr_pkg::SUM_W'(len);
      sum = '0;
      send_byte(bfr_pkg::SYNC_A);
      send_byte(bfr_pkg::SYNC_B);
      // top bit of the length is outside the 15-bit field
      send_byte({1'($urandom_range(1)), l[14:8]});
      send_byte(l[7:0]);
      for (int unsigned i = 0; i < len; i++) begin
         b   = 8'($urandom);
         sum = sum + bfr_pkg::SUM_W'(b);
         send_byte(b);
      end
      ck = {1'($urandom_range(1)), sum};
      if (bad_sum) ck[14:0] = sum ^ bfr_pkg::SUM_W'($urandom_range(32767, 1));
      send_byte(ck[15:8]);
      send_byte(ck[7:0]);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
   endtask

   task automatic send_oversize();
      logic [bfr_pkg::SUM_W-1:0] l;
      l = ($urandom_range(3) == 0)
          ? cur_max + 1'b1
          : bfr_pkg::SUM_W'($urandom_range(32767, 32'(cur_max) + 1));
      send_byte(bfr_pkg::SYNC_A);
      send_byte(bfr_pkg::SYNC_B);
      send_byte({1'($urandom_range(1)), l[14:8]});
      send_byte(l[7:0]);
   endtask

   // stop offering and let every pending response and the pipeline drain
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [bfr_pkg::SUM_W-1:0] v);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      cur_max = v;
      settings_used++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int budget);
      int          start;
      int unsigned r;
      logic [7:0]  b;
      start = frame_bytes;
      while (frame_bytes - start < budget) begin
         r = $urandom_range(99);
         if (r < 66) begin
            send_frame(pick_len(), $urandom_range(99) < 30);
         end else if (r < 76) begin
            if (cur_max < 15'h7FFF) send_oversize();
            else send_frame(pick_len(), 1'b0);
         end else if (r < 79) begin
            wait_drain();
         end else if (r < 83) begin
            steady = 1'b1;
            send_frame(pick_len(), 1'($urandom_range(1)));
            steady = 1'b0;
         end else if (r < 87) begin
            // repeated first sync byte ahead of a frame
            repeat ($urandom_range(3, 1)) send_byte(bfr_pkg::SYNC_A);
            send_frame(pick_len(), 1'b0);
         end else if (r < 91) begin
            // broken sync pair
            b = 8'($urandom);
            if (b == bfr_pkg::SYNC_A || b == bfr_pkg::SYNC_B) b = b ^ 8'h01;
            send_byte(bfr_pkg::SYNC_A);
            send_byte(b);
         end else if (r < 93) begin
            // frame cut short, the receiver swallows what follows
            send_byte(bfr_pkg::SYNC_A);
            send_byte(bfr_pkg::SYNC_B);
            send_byte(8'h00);
            send_byte(8'($urandom_range((cur_max < 15'd20) ? 32'(cur_max) : 20)));
            repeat ($urandom_range(4)) send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
         end
      end
   endtask

   // response side: random stalls, plus one long hold-off when asked
   initial begin
      int hold_served;
      int unsigned stall;
      hold_served  = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_served) begin
            hold_served++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!steady && (stall = pick_gap()) != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // dropped while hunting, then a broken sync pair
      send_byte(bfr_pkg::SYNC_B);
      send_byte(8'h00);
      send_byte(bfr_pkg::SYNC_A);
      send_byte(8'h55);
      // repeated first sync byte, then a zero-length frame
      send_byte(bfr_pkg::SYNC_A);
      send_frame(0, 1'b0);
      // top length bit set and ignored, payload extremes, checksum top bit ignored
      send_byte(bfr_pkg::SYNC_A);
      send_byte(bfr_pkg::SYNC_B);
      send_byte(8'h80);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h81);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte(8'hFF);
      // largest length field, oversize at the reset limit
      send_byte(bfr_pkg::SYNC_A);
      send_byte(bfr_pkg::SYNC_B);
      send_byte(8'hFF);
      send_byte(8'hFF);

      // hold the response side off while requests keep coming
      wait_drain();
      steady = 1'b1;
      hold_asks++;
      send_frame(24, 1'b0);
      steady = 1'b0;

      run_random(80);
      write_max_len('0);
      run_random(40);
      write_max_len(15'h7FFF);
      steady = 1'b1;
      send_frame(40, 1'b0);
      steady = 1'b0;
      run_random(80);
      write_max_len(bfr_pkg::SUM_W'($urandom_range(30, 1)));
      run_random(100);

      wait_drain();
      repeat (10) @(posedge clock);
      $display("covered %0d received bytes under %0d length limits",
               frame_bytes, settings_used);
      $display("responses: %0d payload bytes, %0d good, %0d sum errors, %0d oversize",
               payload_seen, good_seen, bad_sum_seen, oversize_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bfr_pkg.sv
hw/rtl/bfr_req_if.sv
hw/rtl/bfr_rsp_if.sv
hw/rtl/bfr_req_reg.sv
hw/rtl/bfr_parser.sv
hw/rtl/bfr_rsp_reg.sv
hw/rtl/binary_frame_receiver_with_sum_check.sv
tb/sv/bfr_frame_checker.sv
tb/sv/binary_frame_receiver_with_sum_check_tb.sv
